FILE: hdl/shrx_pkg.sv
`default_nettype none
package shrx_pkg;

  localparam int unsigned CfgAddrWidth = 3;

  localparam logic [7:0] FirstHeaderReset  = 8'd76;
  localparam logic [7:0] SecondHeaderReset = 8'd170;

  localparam logic [0:0] RegFirstHeader  = 1'd0;
  localparam logic [0:0] RegSecondHeader = 1'd1;

  localparam logic KindPayload = 1'b0;
  localparam logic KindReport  = 1'b1;

  typedef struct packed {
    logic [7:0] first_header_byte;
    logic [7:0] second_header_byte;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [7:0]  packet_index;
    logic [7:0]  packet_address;
    logic [15:0] payload_length;
    logic        checksum_ok;
    logic [31:0] good_packet_count;
    logic [15:0] skipped_count;
    logic        last;
  } result_t;

endpackage
`default_nettype wire

FILE: hdl/shrx_byte_if.sv
`default_nettype none
interface shrx_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

FILE: hdl/shrx_result_if.sv
`default_nettype none
interface shrx_result_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  payload_byte;
  logic [7:0]  packet_index;
  logic [7:0]  packet_address;
  logic [15:0] payload_length;
  logic        checksum_ok;
  logic [31:0] good_packet_count;
  logic [15:0] skipped_count;
  logic        last;

  modport source (
    output valid, output kind, output payload_byte, output packet_index,
    output packet_address, output payload_length, output checksum_ok,
    output good_packet_count, output skipped_count, output last,
    input ready
  );
  modport sink (
    input valid, input kind, input payload_byte, input packet_index,
    input packet_address, input payload_length, input checksum_ok,
    input good_packet_count, input skipped_count, input last,
    output ready
  );
endinterface
`default_nettype wire

FILE: hdl/shrx_cfg.sv
`default_nettype none
module shrx_cfg (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [shrx_pkg::CfgAddrWidth-1:0]  paddr,
  input  wire logic [31:0]                        pwdata,
  output logic      [31:0]                        prdata,
  output logic                                    pready,
  output shrx_pkg::cfg_t                          cfg
);

  logic       wr_en;
  logic [0:0] reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.first_header_byte  <= shrx_pkg::FirstHeaderReset;
      cfg.second_header_byte <= shrx_pkg::SecondHeaderReset;
    end else if (wr_en) begin
      case (reg_sel)
        shrx_pkg::RegFirstHeader:  cfg.first_header_byte  <= pwdata[7:0];
        shrx_pkg::RegSecondHeader: cfg.second_header_byte <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      shrx_pkg::RegFirstHeader:  prdata = {24'd0, cfg.first_header_byte};
      shrx_pkg::RegSecondHeader: prdata = {24'd0, cfg.second_header_byte};
      default:                   prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

FILE: hdl/shrx_core.sv
`default_nettype none
module shrx_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire shrx_pkg::cfg_t  cfg,
  input  wire logic            in_valid,
  input  wire logic [7:0]      in_byte,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output shrx_pkg::result_t    out_res
);

  localparam logic [3:0] PH_HDR1   = 4'd0;
  localparam logic [3:0] PH_HDR2   = 4'd1;
  localparam logic [3:0] PH_INDEX  = 4'd2;
  localparam logic [3:0] PH_ADDR   = 4'd3;
  localparam logic [3:0] PH_LEN_LO = 4'd4;
  localparam logic [3:0] PH_LEN_HI = 4'd5;
  localparam logic [3:0] PH_DATA   = 4'd6;
  localparam logic [3:0] PH_SUM    = 4'd7;
  localparam logic [3:0] PH_XOR    = 4'd8;

  // input register
  logic        byte_valid;
  logic [7:0]  byte_q;

  // frame state
  logic [3:0]  rx_phase, rx_phase_next;
  logic [7:0]  held_index, held_index_next;
  logic [7:0]  held_address, held_address_next;
  logic [15:0] held_length, held_length_next;
  logic [15:0] bytes_seen, bytes_seen_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [7:0]  running_xor, running_xor_next;
  logic [7:0]  sum_trailer, sum_trailer_next;
  logic [31:0] good_packets, good_packets_next;
  logic [15:0] skipped_bytes, skipped_bytes_next;

  logic        fire;
  logic        emit;
  logic [1:0]  skip_add;
  logic [16:0] skip_sum;
  logic [16:0] seen_inc;
  logic        ok;
  shrx_pkg::result_t res_next;

  assign fire     = byte_valid && (!out_valid || out_ready);
  assign in_ready = !byte_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (in_ready) begin
      byte_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_q <= in_byte;
    end
  end

  assign skip_sum = {1'b0, skipped_bytes} + {15'd0, skip_add};
  assign seen_inc = {1'b0, bytes_seen} + 17'd1;
  assign ok       = (sum_trailer == running_sum) && (byte_q == running_xor);

  always_comb begin
    rx_phase_next     = rx_phase;
    held_index_next   = held_index;
    held_address_next = held_address;
    held_length_next  = held_length;
    bytes_seen_next   = bytes_seen;
    running_sum_next  = running_sum;
    running_xor_next  = running_xor;
    sum_trailer_next  = sum_trailer;
    good_packets_next = good_packets;
    skip_add          = 2'd0;
    emit              = 1'b0;
    res_next          = '0;
    case (rx_phase)
      PH_HDR2: begin
        if (byte_q == cfg.second_header_byte) begin
          rx_phase_next = PH_INDEX;
        end else if (byte_q == cfg.first_header_byte) begin
          skip_add = 2'd1;
        end else begin
          rx_phase_next = PH_HDR1;
          skip_add      = 2'd2;
        end
      end
      PH_INDEX: begin
        held_index_next  = byte_q;
        running_sum_next = 8'd0;
        running_xor_next = 8'd0;
        bytes_seen_next  = 16'd0;
        rx_phase_next    = PH_ADDR;
      end
      PH_ADDR: begin
        held_address_next = byte_q;
        rx_phase_next     = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        held_length_next = {8'd0, byte_q};
        rx_phase_next    = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        held_length_next = {byte_q, held_length[7:0]};
        rx_phase_next    = ({byte_q, held_length[7:0]} == 16'd0) ? PH_SUM : PH_DATA;
      end
      PH_DATA: begin
        running_sum_next = running_sum + byte_q;
        running_xor_next = running_xor ^ byte_q;
        bytes_seen_next  = seen_inc[15:0];
        if (seen_inc >= {1'b0, held_length}) begin
          rx_phase_next = PH_SUM;
        end
        emit                       = 1'b1;
        res_next.kind              = shrx_pkg::KindPayload;
        res_next.payload_byte      = byte_q;
        res_next.packet_index      = held_index;
        res_next.packet_address    = held_address;
        res_next.payload_length    = held_length;
        res_next.checksum_ok       = 1'b0;
        res_next.good_packet_count = good_packets;
        res_next.skipped_count     = skipped_bytes;
        res_next.last              = 1'b0;
      end
      PH_SUM: begin
        sum_trailer_next = byte_q;
        rx_phase_next    = PH_XOR;
      end
      PH_XOR: begin
        if (ok) begin
          good_packets_next = good_packets + 32'd1;
        end
        rx_phase_next              = PH_HDR1;
        emit                       = 1'b1;
        res_next.kind              = shrx_pkg::KindReport;
        res_next.payload_byte      = 8'd0;
        res_next.packet_index      = held_index;
        res_next.packet_address    = held_address;
        res_next.payload_length    = held_length;
        res_next.checksum_ok       = ok;
        res_next.good_packet_count = good_packets_next;
        res_next.skipped_count     = skipped_bytes;
        res_next.last              = 1'b1;
      end
      default: begin
        if (byte_q == cfg.first_header_byte) begin
          rx_phase_next = PH_HDR2;
        end else begin
          rx_phase_next = PH_HDR1;
          skip_add      = 2'd1;
        end
      end
    endcase
    // saturating hunt count, cleared after each report
    if (rx_phase == PH_XOR) begin
      skipped_bytes_next = 16'd0;
    end else if (skip_sum[16]) begin
      skipped_bytes_next = 16'hFFFF;
    end else begin
      skipped_bytes_next = skip_sum[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_phase      <= PH_HDR1;
      held_index    <= 8'd0;
      held_address  <= 8'd0;
      held_length   <= 16'd0;
      bytes_seen    <= 16'd0;
      running_sum   <= 8'd0;
      running_xor   <= 8'd0;
      sum_trailer   <= 8'd0;
      good_packets  <= 32'd0;
      skipped_bytes <= 16'd0;
    end else if (fire) begin
      rx_phase      <= rx_phase_next;
      held_index    <= held_index_next;
      held_address  <= held_address_next;
      held_length   <= held_length_next;
      bytes_seen    <= bytes_seen_next;
      running_sum   <= running_sum_next;
      running_xor   <= running_xor_next;
      sum_trailer   <= sum_trailer_next;
      good_packets  <= good_packets_next;
      skipped_bytes <= skipped_bytes_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_res <= res_next;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/sync_header_packet_receiver_unit.sv
// channel   direction  payload
// rx        in         rx_byte
// res       out        kind, payload_byte, packet_index, packet_address, payload_length,
//                      checksum_ok, good_packet_count, skipped_count, last
// apb       in/out     header byte registers at 0x0 and 0x4
//
// one byte per cycle while res is not stalled; a byte is held in the input register and its result
// (payload byte or end report) is then registered in the result register
// header, index, address, length and sum trailer bytes produce no transfer on res
// synchronous reset returns to the header hunt with all counters cleared
// a stalled res holds its result and blocks rx only once the input register is full
`default_nettype none
module sync_header_packet_receiver_unit (
  input  wire logic                               clk,
  input  wire logic                               rst,
  shrx_byte_if.sink                               rx,
  shrx_result_if.source                           res,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [shrx_pkg::CfgAddrWidth-1:0]  paddr,
  input  wire logic [31:0]                        pwdata,
  output logic      [31:0]                        prdata,
  output logic                                    pready
);

  shrx_pkg::cfg_t    cfg;
  shrx_pkg::result_t out_res;

  shrx_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  shrx_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (rx.valid),
    .in_byte   (rx.rx_byte),
    .in_ready  (rx.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_res   (out_res)
  );

  assign res.kind              = out_res.kind;
  assign res.payload_byte      = out_res.payload_byte;
  assign res.packet_index      = out_res.packet_index;
  assign res.packet_address    = out_res.packet_address;
  assign res.payload_length    = out_res.payload_length;
  assign res.checksum_ok       = out_res.checksum_ok;
  assign res.good_packet_count = out_res.good_packet_count;
  assign res.skipped_count     = out_res.skipped_count;
  assign res.last              = out_res.last;

endmodule
`default_nettype wire
